// File: src/priority_led_indication_stack_core_assert.svh
// ----------------------------------------------------------------------------
// priority_led_indication_stack_core_assert
// Assertion helpers for the LED indication stack.
// ----------------------------------------------------------------------------
// Each macro takes a label, a clock, an active-low reset, a condition,
// a consequence and a message.
`ifndef PRIORITY_LED_INDICATION_STACK_CORE_ASSERT_SVH
`define PRIORITY_LED_INDICATION_STACK_CORE_ASSERT_SVH

// consequence holds in the same cycle
`define PLIS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the next cycle
`define PLIS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/plis_pkg.sv
// ----------------------------------------------------------------------------
// plis_pkg
// Types and constants shared by the LED indication stack modules.
// ----------------------------------------------------------------------------
package plis_pkg;

  localparam int PRIORITIES_DEF = 8;

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_OFF    = 3'd1,
    OP_DONE   = 3'd2,
    OP_MASK   = 3'd3,
    OP_UNMASK = 3'd4,
    OP_STOP   = 3'd5,
    OP_START  = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_STEADY  = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_COUNTED = 2'd2,
    MODE_BAD     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DRV_OFF    = 2'd0,
    DRV_STEADY = 2'd1,
    DRV_BLINK  = 2'd2
  } drv_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_SET,
    ACT_DEL
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_RERUN,
    ST_FINISH
  } state_t;

  // one list entry
  typedef struct packed {
    logic [2:0]  level;
    logic [1:0]  mode;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] blinks;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    act_t       act;
    logic [2:0] level;
    logic       full;
  } cell_ctl_t;

  typedef struct packed {
    logic        reissued;
    drv_t        kind;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] count;
  } res_t;

endpackage

// File: src/plis_in_if.sv
// ----------------------------------------------------------------------------
// plis_in_if
// Request channel of the LED indication stack.
// ----------------------------------------------------------------------------
interface plis_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [2:0]  level;
  logic [1:0]  mode;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;
  logic [15:0] on_time_ms;
  logic [15:0] off_time_ms;
  logic [15:0] blink_total;

  modport source (
    output valid, operation, level, mode, red, green, blue,
           on_time_ms, off_time_ms, blink_total,
    input  ready
  );

  modport sink (
    input  valid, operation, level, mode, red, green, blue,
           on_time_ms, off_time_ms, blink_total,
    output ready
  );
endinterface

// File: src/plis_out_if.sv
// ----------------------------------------------------------------------------
// plis_out_if
// Drive command channel of the LED indication stack.
// ----------------------------------------------------------------------------
interface plis_out_if;
  logic        valid;
  logic        ready;
  logic        reissued;
  logic [1:0]  drive_kind;
  logic [15:0] drive_red;
  logic [15:0] drive_green;
  logic [15:0] drive_blue;
  logic [15:0] drive_on_ms;
  logic [15:0] drive_off_ms;
  logic [15:0] drive_count;

  modport source (
    output valid, reissued, drive_kind, drive_red, drive_green, drive_blue,
           drive_on_ms, drive_off_ms, drive_count,
    input  ready
  );

  modport sink (
    input  valid, reissued, drive_kind, drive_red, drive_green, drive_blue,
           drive_on_ms, drive_off_ms, drive_count,
    output ready
  );
endinterface

// File: src/plis_cell.sv
// ----------------------------------------------------------------------------
// plis_cell
// One list slot. Loads the new entry, its left or its right neighbor.
// ----------------------------------------------------------------------------
module plis_cell (
  input  logic               clk,
  input  plis_pkg::cell_ctl_t ctl,
  input  logic               any_eq,
  input  plis_pkg::slot_t    new_slot,
  input  plis_pkg::slot_t    left_slot,
  input  plis_pkg::slot_t    right_slot,
  input  logic               left_lt,
  input  logic               left_occ,
  input  logic               occ,
  output plis_pkg::slot_t    slot,
  output logic               lt,
  output logic               eq
);

  plis_pkg::slot_t slot_r, slot_nxt;

  assign lt   = occ && (slot_r.level < ctl.level);
  assign eq   = occ && (slot_r.level == ctl.level);
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    case (ctl.act)
      plis_pkg::ACT_SET: begin
        if (any_eq) begin
          if (eq) slot_nxt = new_slot;
        end else if (!ctl.full) begin
          // insert point sits right after the last lower level
          if (!lt && left_lt) slot_nxt = new_slot;
          else if (left_occ && !left_lt) slot_nxt = left_slot;
        end
      end
      plis_pkg::ACT_DEL: begin
        if (any_eq && occ && (slot_r.level >= ctl.level)) slot_nxt = right_slot;
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// File: src/plis_row.sv
// ----------------------------------------------------------------------------
// plis_row
// Row of slot cells kept sorted by ascending level; slot 0 is the lowest.
// ----------------------------------------------------------------------------
module plis_row #(
  parameter  int PRIORITIES = plis_pkg::PRIORITIES_DEF,
  localparam int CNT_W      = $clog2(PRIORITIES + 1),
  localparam int IDX_W      = $clog2(PRIORITIES)
) (
  input  logic                clk,
  input  plis_pkg::cell_ctl_t ctl,
  input  plis_pkg::slot_t     new_slot,
  input  logic [CNT_W-1:0]    fill,
  output plis_pkg::slot_t     top_slot,
  output logic                any_eq
);

  plis_pkg::slot_t        slots [PRIORITIES];
  logic [PRIORITIES-1:0]  lt;
  logic [PRIORITIES-1:0]  eq;
  logic [PRIORITIES-1:0]  occ;

  assign any_eq   = |eq;
  assign top_slot = slots[IDX_W'(fill - CNT_W'(1))];

  genvar k;
  generate
    for (k = 0; k < PRIORITIES; k++) begin : g_cell
      plis_pkg::slot_t left_s, right_s;
      logic            left_lt_s, left_occ_s;

      assign occ[k] = (CNT_W'(k) < fill);

      if (k == 0) begin : g_first
        // a virtual lower neighbor: always occupied and below any level
        assign left_s     = slots[k];
        assign left_lt_s  = 1'b1;
        assign left_occ_s = 1'b1;
      end else begin : g_mid
        assign left_s     = slots[k-1];
        assign left_lt_s  = lt[k-1];
        assign left_occ_s = occ[k-1];
      end

      if (k == PRIORITIES - 1) begin : g_last
        assign right_s = slots[k];
      end else begin : g_inner
        assign right_s = slots[k+1];
      end

      plis_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .any_eq     (any_eq),
        .new_slot   (new_slot),
        .left_slot  (left_s),
        .right_slot (right_s),
        .left_lt    (left_lt_s),
        .left_occ   (left_occ_s),
        .occ        (occ[k]),
        .slot       (slots[k]),
        .lt         (lt[k]),
        .eq         (eq[k])
      );
    end
  endgenerate

endmodule

// File: src/priority_led_indication_stack_core.sv
// ----------------------------------------------------------------------------
// priority_led_indication_stack_core
// Priority stack of LED indication requests driving one LED command.
//
//   channel  | port    | direction | contents
//   ---------+---------+-----------+----------------------------------------
//   request  | in_req  | in        | operation, level, mode, colour, times
//   drive    | out_rsp | out       | reissued flag and current drive command
//
// A request runs from acceptance through the execute step, for a valid set or
// off the check step, where needed the top-removal loop over the cell row that
// drops masked top entries, and the finish step. The next request is taken in
// the cycle after the drive command is loaded into the output register.
// Reset is synchronous, active low; the slot row holds no reset values.
// A stalled drive channel holds the block in its last step until taken.
// ----------------------------------------------------------------------------
`include "priority_led_indication_stack_core_assert.svh"

module priority_led_indication_stack_core #(
  parameter int PRIORITIES = plis_pkg::PRIORITIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  plis_in_if.sink    in_req,
  plis_out_if.source out_rsp
);

  localparam int CNT_W = $clog2(PRIORITIES + 1);
  localparam logic [PRIORITIES-1:0] MASK_ONE = {{(PRIORITIES-1){1'b0}}, 1'b1};
  localparam logic [CNT_W-1:0] FILL_ONE = CNT_W'(1);

  plis_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [PRIORITIES-1:0] mask_r, mask_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 re_r, re_nxt;
  logic                 was_empty_r, was_empty_nxt;
  logic                 out_valid_r, out_valid_nxt;

  plis_pkg::op_t        op_r;
  plis_pkg::slot_t      req_r;
  plis_pkg::slot_t      old_top_r, old_top_nxt;
  plis_pkg::res_t       out_r, out_nxt;

  plis_pkg::cell_ctl_t  ctl;
  plis_pkg::slot_t      top_slot;
  logic                 any_eq;
  logic                 in_acc;
  logic                 out_load;
  logic                 lv_ok;
  logic                 empty;
  logic [PRIORITIES-1:0] mask_sh;

  assign in_req.ready = (state_r == plis_pkg::ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign lv_ok        = (32'(req_r.level) < PRIORITIES);
  assign empty        = (fill_r == '0);

  assign mask_sh = mask_r >> top_slot.level;

  plis_row #(.PRIORITIES(PRIORITIES)) u_row (
    .clk      (clk),
    .ctl      (ctl),
    .new_slot (req_r),
    .fill     (fill_r),
    .top_slot (top_slot),
    .any_eq   (any_eq)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    mask_nxt      = mask_r;
    stopped_nxt   = stopped_r;
    re_nxt        = re_r;
    was_empty_nxt = was_empty_r;
    old_top_nxt   = old_top_r;
    ctl.act       = plis_pkg::ACT_HOLD;
    ctl.level     = req_r.level;
    ctl.full      = (fill_r == CNT_W'(PRIORITIES));
    out_load      = 1'b0;

    case (state_r)
      plis_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = plis_pkg::ST_EXEC;
      end

      plis_pkg::ST_EXEC: begin
        re_nxt    = 1'b0;
        state_nxt = plis_pkg::ST_FINISH;
        case (op_r)
          plis_pkg::OP_SET, plis_pkg::OP_OFF: begin
            if (lv_ok) begin
              old_top_nxt   = top_slot;
              was_empty_nxt = empty;
              state_nxt     = plis_pkg::ST_CHECK;
              if (op_r == plis_pkg::OP_OFF) begin
                ctl.act = plis_pkg::ACT_DEL;
                if (any_eq) fill_nxt = fill_r - FILL_ONE;
              end else if (req_r.mode != plis_pkg::MODE_BAD) begin
                ctl.act = plis_pkg::ACT_SET;
                if (!any_eq && !ctl.full) fill_nxt = fill_r + FILL_ONE;
              end
            end
          end
          plis_pkg::OP_DONE: begin
            if (!empty) begin
              fill_nxt  = fill_r - FILL_ONE;
              state_nxt = plis_pkg::ST_RERUN;
            end
          end
          plis_pkg::OP_MASK: begin
            if (lv_ok) begin
              mask_nxt = mask_r | (MASK_ONE << req_r.level);
              if (!empty && top_slot.level == req_r.level) state_nxt = plis_pkg::ST_RERUN;
            end
          end
          plis_pkg::OP_UNMASK: begin
            if (lv_ok) mask_nxt = mask_r & ~(MASK_ONE << req_r.level);
          end
          plis_pkg::OP_STOP: begin
            if (!stopped_r) begin
              stopped_nxt = 1'b1;
              re_nxt      = 1'b1;
            end
          end
          plis_pkg::OP_START: begin
            if (stopped_r) begin
              stopped_nxt = 1'b0;
              state_nxt   = plis_pkg::ST_RERUN;
            end
          end
          default: state_nxt = plis_pkg::ST_FINISH;
        endcase
      end

      plis_pkg::ST_CHECK: begin
        if (was_empty_r || empty || (top_slot != old_top_r)) state_nxt = plis_pkg::ST_RERUN;
        else state_nxt = plis_pkg::ST_FINISH;
      end

      plis_pkg::ST_RERUN: begin
        // drop masked entries off the top one per cycle
        if (!empty && mask_sh[0]) begin
          fill_nxt = fill_r - FILL_ONE;
        end else begin
          re_nxt    = !stopped_r;
          state_nxt = plis_pkg::ST_FINISH;
        end
      end

      plis_pkg::ST_FINISH: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = plis_pkg::ST_IDLE;
        end
      end

      default: state_nxt = plis_pkg::ST_IDLE;
    endcase
  end

  // drive command from the current top, or off while stopped or empty
  always_comb begin
    out_nxt          = '0;
    out_nxt.reissued = re_r;
    out_nxt.kind     = plis_pkg::DRV_OFF;
    if (!stopped_r && !empty) begin
      out_nxt.red   = top_slot.red;
      out_nxt.green = top_slot.green;
      out_nxt.blue  = top_slot.blue;
      if (top_slot.mode == plis_pkg::MODE_STEADY) begin
        out_nxt.kind = plis_pkg::DRV_STEADY;
      end else begin
        out_nxt.kind   = plis_pkg::DRV_BLINK;
        out_nxt.on_ms  = top_slot.on_ms;
        out_nxt.off_ms = top_slot.off_ms;
        out_nxt.count  = top_slot.blinks;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_rsp.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plis_pkg::ST_IDLE;
      fill_r      <= '0;
      mask_r      <= '0;
      stopped_r   <= 1'b0;
      re_r        <= 1'b0;
      was_empty_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      mask_r      <= mask_nxt;
      stopped_r   <= stopped_nxt;
      re_r        <= re_nxt;
      was_empty_r <= was_empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    old_top_r <= old_top_nxt;
    if (in_acc) begin
      op_r          <= plis_pkg::op_t'(in_req.operation);
      req_r.level   <= in_req.level;
      req_r.mode    <= in_req.mode;
      req_r.red     <= in_req.red;
      req_r.green   <= in_req.green;
      req_r.blue    <= in_req.blue;
      req_r.on_ms   <= in_req.on_time_ms;
      req_r.off_ms  <= in_req.off_time_ms;
      req_r.blinks  <= in_req.blink_total;
    end
    if (out_load) out_r <= out_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.reissued     = out_r.reissued;
  assign out_rsp.drive_kind   = out_r.kind;
  assign out_rsp.drive_red    = out_r.red;
  assign out_rsp.drive_green  = out_r.green;
  assign out_rsp.drive_blue   = out_r.blue;
  assign out_rsp.drive_on_ms  = out_r.on_ms;
  assign out_rsp.drive_off_ms = out_r.off_ms;
  assign out_rsp.drive_count  = out_r.count;

  `PLIS_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_acc,
    state_r == plis_pkg::ST_EXEC, "accepted request did not start execution")

  `PLIS_ASSERT_NEXT(a_rerun_pop, clk, rst_n,
    (state_r == plis_pkg::ST_RERUN) && !empty && mask_sh[0],
    fill_r == CNT_W'($past(fill_r) - FILL_ONE), "masked top entry was not dropped")

  `PLIS_ASSERT_NEXT(a_stopped_off, clk, rst_n, out_load && stopped_r,
    out_r.kind == plis_pkg::DRV_OFF, "drive not off while stopped")

  `PLIS_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1,
    fill_r <= CNT_W'(PRIORITIES), "entry count exceeds list depth")

endmodule
